[rtl/core/wbps_pkg.sv]
`timescale 1ns / 1ps

package wbps_pkg;

  // pattern depth and offset counter size
  localparam int PATTERN_MAX = 16;
  localparam int OFFSET_BITS = 32;

  // fixed field widths
  localparam int DATA_W     = 8;
  localparam int ADDR_W     = 64;
  localparam int MASK_W     = 16;
  localparam int LEN_W      = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int PAT_W      = 2 * CFG_DATA_W;

  // window index width
  localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  localparam logic [OFFSET_BITS-1:0] COUNT_MAX = {OFFSET_BITS{1'b1}};

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LOW   = 3'd0,
    CFG_PAT_HIGH  = 3'd1,
    CFG_CARE_MASK = 3'd2,
    CFG_PAT_LEN   = 3'd3,
    CFG_BASE_ADDR = 3'd4
  } cfg_reg_t;

  // newest byte at index 0
  typedef logic [PATTERN_MAX-1:0][DATA_W-1:0] window_t;

  // window stage contents handed to the matcher
  typedef struct packed {
    logic                   valid;
    logic                   last;
    logic [OFFSET_BITS-1:0] count;
    window_t                window;
  } win_stage_t;

  // configuration seen by the matcher
  typedef struct packed {
    logic [PAT_W-1:0]  pattern;
    logic [MASK_W-1:0] care;
    logic [LEN_W-1:0]  length;
    logic [ADDR_W-1:0] base;
  } scan_cfg_t;

endpackage

[rtl/core/wildcard_byte_pattern_scan_core.sv]
`timescale 1ns / 1ps

// Wildcard byte pattern scanner.
// Input channel (in_valid/in_ready): one byte of a memory image per item, with
// in_last_byte marking the final byte. Result channel (out_valid/out_ready):
// at most one item per image. out_found=1 with out_match_address = base
// address plus start offset at the first full match of the configured
// pattern (care mask clear = wildcard byte); later bytes of the image, the
// last one included, give nothing. If the last byte arrives with no match,
// out_found=0 and address 0 are returned. The next image starts clean after
// the last byte. Configuration (cfg_we/cfg_index/cfg_wdata) writes one
// register per cycle; the user must write it only while no image is in
// flight, as the block itself does not enforce this.
// The byte enters the window register when it is accepted, and the result
// register loads from the window stage when that stage advances.
// Throughput: 1 byte per cycle while the receiver takes results; the window
// compare and the address add sit between the window and result registers.
// When the receiver stalls, the result holds and one more byte may be taken
// into the window stage; then in_ready drops until the result is taken.
// Reset (rst_n low, synchronous) clears the config registers, window, byte
// count and match-done flag (not the found flag); no clearing pass is needed.

module wildcard_byte_pattern_scan_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [wbps_pkg::DATA_W-1:0]     in_data_byte,
  input  logic                            in_last_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_found,
  output logic [wbps_pkg::ADDR_W-1:0]     out_match_address,
  input  logic                            cfg_we,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // configuration registers
  logic [wbps_pkg::CFG_DATA_W-1:0] pat_low_r;
  logic [wbps_pkg::CFG_DATA_W-1:0] pat_high_r;
  logic [wbps_pkg::MASK_W-1:0]     care_r;
  logic [wbps_pkg::LEN_W-1:0]      len_r;
  logic [wbps_pkg::ADDR_W-1:0]     base_r;

  wbps_pkg::scan_cfg_t  cfg;
  wbps_pkg::win_stage_t stage;
  logic                 advance;

  // register writes; unused indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      care_r     <= '0;
      len_r      <= '0;
      base_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wbps_pkg::CFG_PAT_LOW:   pat_low_r  <= cfg_wdata;
        wbps_pkg::CFG_PAT_HIGH:  pat_high_r <= cfg_wdata;
        wbps_pkg::CFG_CARE_MASK: care_r     <= cfg_wdata[wbps_pkg::MASK_W-1:0];
        wbps_pkg::CFG_PAT_LEN:   len_r      <= cfg_wdata[wbps_pkg::LEN_W-1:0];
        wbps_pkg::CFG_BASE_ADDR: base_r     <= cfg_wdata[wbps_pkg::ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // byte 0 of the pattern sits in the low bits of the low word
  assign cfg.pattern = {pat_high_r, pat_low_r};
  assign cfg.care    = care_r;
  assign cfg.length  = len_r;
  assign cfg.base    = base_r;

  // window stage: shift register of recent bytes plus saturating byte count
  wbps_window u_window (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .advance      (advance),
    .stage        (stage)
  );

  // compare stage: pattern match, match-done tracking and result register
  wbps_match u_match (
    .clk               (clk),
    .rst_n             (rst_n),
    .stage             (stage),
    .cfg               (cfg),
    .advance           (advance),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_found         (out_found),
    .out_match_address (out_match_address)
  );

endmodule

[rtl/core/wbps_window.sv]
`timescale 1ns / 1ps

module wbps_window (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [wbps_pkg::DATA_W-1:0] in_data_byte,
  input  logic                        in_last_byte,
  input  logic                        advance,
  output wbps_pkg::win_stage_t        stage
);

  logic                             valid_r, valid_nxt;
  logic                             last_r, last_nxt;
  logic [wbps_pkg::OFFSET_BITS-1:0] count_r, count_nxt;
  wbps_pkg::window_t                window_r, window_nxt;

  logic                             accept;
  logic [wbps_pkg::OFFSET_BITS-1:0] count_base;
  wbps_pkg::window_t                window_base;

  assign in_ready = !valid_r || advance;
  assign accept   = in_valid && in_ready;

  // state of the previous image is dropped lazily once its last item has moved in
  assign count_base  = last_r ? '0 : count_r;
  assign window_base = last_r ? '0 : window_r;

  always_comb begin
    valid_nxt  = valid_r;
    last_nxt   = last_r;
    count_nxt  = count_r;
    window_nxt = window_r;
    if (accept) begin
      valid_nxt     = 1'b1;
      last_nxt      = in_last_byte;
      count_nxt     = (count_base == wbps_pkg::COUNT_MAX) ? count_base
                                                          : count_base + 1'b1;
      window_nxt[0] = in_data_byte;
      for (int k = 1; k < wbps_pkg::PATTERN_MAX; k++) begin
        window_nxt[k] = window_base[k-1];
      end
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      last_r   <= 1'b0;
      count_r  <= '0;
      window_r <= '0;
    end else begin
      valid_r  <= valid_nxt;
      last_r   <= last_nxt;
      count_r  <= count_nxt;
      window_r <= window_nxt;
    end
  end

  assign stage.valid  = valid_r;
  assign stage.last   = last_r;
  assign stage.count  = count_r;
  assign stage.window = window_r;

endmodule

[rtl/core/wbps_match.sv]
`timescale 1ns / 1ps

module wbps_match (
  input  logic                        clk,
  input  logic                        rst_n,
  input  wbps_pkg::win_stage_t        stage,
  input  wbps_pkg::scan_cfg_t         cfg,
  output logic                        advance,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_found,
  output logic [wbps_pkg::ADDR_W-1:0] out_match_address
);

  logic                             out_valid_r, out_valid_nxt;
  logic                             done_r, done_nxt;
  logic                             found_r, found_nxt;
  logic [wbps_pkg::ADDR_W-1:0]      addr_r, addr_nxt;

  logic                             take;
  logic                             emit;
  logic                             hit;
  logic [wbps_pkg::LEN_W-1:0]       idx;
  logic [wbps_pkg::OFFSET_BITS-1:0] offset;

  assign advance = !out_valid_r || out_ready;
  assign take    = stage.valid && advance;

  // parallel compare of the window against the pattern, wildcards skipped
  always_comb begin
    hit = 1'b1;
    idx = '0;
    if (cfg.length == '0 ||
        cfg.length > wbps_pkg::LEN_W'(wbps_pkg::PATTERN_MAX) ||
        stage.count < wbps_pkg::OFFSET_BITS'(cfg.length)) begin
      hit = 1'b0;
    end
    for (int j = 0; j < wbps_pkg::PATTERN_MAX; j++) begin
      idx = cfg.length - wbps_pkg::LEN_W'(j) - 1'b1;
      if (wbps_pkg::LEN_W'(j) < cfg.length && cfg.care[j]) begin
        if (stage.window[idx[wbps_pkg::IDX_W-1:0]] !=
            cfg.pattern[j*wbps_pkg::DATA_W +: wbps_pkg::DATA_W]) begin
          hit = 1'b0;
        end
      end
    end
  end

  assign offset = stage.count - wbps_pkg::OFFSET_BITS'(cfg.length);
  assign emit   = !done_r && (hit || stage.last);

  always_comb begin
    out_valid_nxt = out_valid_r;
    done_nxt      = done_r;
    found_nxt     = found_r;
    addr_nxt      = addr_r;
    if (take) begin
      done_nxt = stage.last ? 1'b0 : (done_r || hit);
    end
    if (take && emit) begin
      out_valid_nxt = 1'b1;
      found_nxt     = hit;
      addr_nxt      = hit ? cfg.base + wbps_pkg::ADDR_W'(offset) : '0;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      done_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      done_r      <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_r <= found_nxt;
    addr_r  <= addr_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_found         = found_r;
  assign out_match_address = addr_r;

endmodule

[rtl/core/wbps_checker.sv]
`timescale 1ns / 1ps

module wbps_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_found,
  input logic [wbps_pkg::ADDR_W-1:0] out_match_address
);

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found) &&
                                $stable(out_match_address))
    else $error("stalled result changed");

  // a no-match result carries a zero address
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_match_address == '0)
    else $error("no-match result with nonzero address");

  // input side never blocks while the result slot is free
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with free result slot");

endmodule

bind wildcard_byte_pattern_scan_core wbps_checker u_wbps_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_found         (out_found),
  .out_match_address (out_match_address)
);

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

  // one result item: hit flag and the address of the hit
  typedef struct packed {
    logic                        found;
    logic [wbps_pkg::ADDR_W-1:0] address;
  } scan_hit_t;

  // tracks the scanner's registers and image state, predicts and checks hits
  class scan_checker;
    logic [wbps_pkg::CFG_DATA_W-1:0]  pat_low;
    logic [wbps_pkg::CFG_DATA_W-1:0]  pat_high;
    logic [wbps_pkg::MASK_W-1:0]      care;
    logic [wbps_pkg::LEN_W-1:0]       plen;
    logic [wbps_pkg::ADDR_W-1:0]      base;
    // newest byte at index 0
    logic [wbps_pkg::DATA_W-1:0]      window [wbps_pkg::PATTERN_MAX];
    logic [wbps_pkg::OFFSET_BITS-1:0] seen;
    bit                               hit_done;
    scan_hit_t                        pending_hits [$];
    int                               errors;

    function new();
      pat_low  = '0;
      pat_high = '0;
      care     = '0;
      plen     = '0;
      base     = '0;
      errors   = 0;
      clear_image();
    endfunction

    function void clear_image();
      foreach (window[k]) window[k] = '0;
      seen     = '0;
      hit_done = 1'b0;
    endfunction

    function logic [wbps_pkg::DATA_W-1:0] pattern_byte(int j);
      logic [wbps_pkg::PAT_W-1:0] pat;
      pat = {pat_high, pat_low};
      return pat[j*wbps_pkg::DATA_W +: wbps_pkg::DATA_W];
    endfunction

    function void write_reg(wbps_pkg::cfg_reg_t idx,
                            logic [wbps_pkg::CFG_DATA_W-1:0] v);
      unique case (idx)
        wbps_pkg::CFG_PAT_LOW:   pat_low  = v;
        wbps_pkg::CFG_PAT_HIGH:  pat_high = v;
        wbps_pkg::CFG_CARE_MASK: care     = v[wbps_pkg::MASK_W-1:0];
        wbps_pkg::CFG_PAT_LEN:   plen     = v[wbps_pkg::LEN_W-1:0];
        wbps_pkg::CFG_BASE_ADDR: base     = v;
        default: ;
      endcase
    endfunction

    // oldest byte of the window lines up with pattern byte 0
    function bit window_hit();
      int len;
      int j;
      len = plen;
      if (len == 0 || len > wbps_pkg::PATTERN_MAX) return 1'b0;
      if (seen < len) return 1'b0;
      for (j = 0; j < len; j++) begin
        if (care[j] && window[len-1-j] != pattern_byte(j)) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_byte(logic [wbps_pkg::DATA_W-1:0] b, logic lst);
      scan_hit_t h;
      int k;
      if (!hit_done) begin
        for (k = wbps_pkg::PATTERN_MAX - 1; k > 0; k--) window[k] = window[k-1];
        window[0] = b;
        if (seen != wbps_pkg::COUNT_MAX) seen++;
        if (window_hit()) begin
          hit_done  = 1'b1;
          h.found   = 1'b1;
          h.address = base +
            ({{(wbps_pkg::ADDR_W-wbps_pkg::OFFSET_BITS){1'b0}}, seen} -
             {{(wbps_pkg::ADDR_W-wbps_pkg::LEN_W){1'b0}}, plen});
          pending_hits = {pending_hits, h};
        end else if (lst) begin
          h.found   = 1'b0;
          h.address = '0;
          pending_hits = {pending_hits, h};
        end
      end
      if (lst) clear_image();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("check error: %s", msg);
    endtask

    task check_result(logic found, logic [wbps_pkg::ADDR_W-1:0] address);
      scan_hit_t h;
      if (pending_hits.size() == 0) begin
        report($sformatf("result with none pending: found=%0b addr=%h", found, address));
        return;
      end
      h = pending_hits.pop_front();
      if (found !== h.found)
        report($sformatf("found %0b, predicted %0b", found, h.found));
      if (address !== h.address)
        report($sformatf("match_address %h, predicted %h", address, h.address));
    endtask
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  logic [wbps_pkg::DATA_W-1:0]     in_data_byte;
  logic                            in_last_byte;
  logic                            out_valid;
  logic                            out_ready;
  logic                            out_found;
  logic [wbps_pkg::ADDR_W-1:0]     out_match_address;
  logic                            cfg_we;
  logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [wbps_pkg::CFG_DATA_W-1:0] cfg_wdata;

  scan_checker  sb;
  logic [7:0]   image_q [$];
  bit           send_idle;
  bit           recv_idle;
  bit           press_on;
  int           sent;

  wildcard_byte_pattern_scan_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_found         (out_found),
    .out_match_address (out_match_address),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // handshakes sampled at the edge with pre-edge values
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_byte(in_data_byte, in_last_byte);
      if (out_valid && out_ready) sb.check_result(out_found, out_match_address);
    end
  end

  // receiver: ready drops in random bursts while stalls are on
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (recv_idle && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // hold the sender off until every predicted result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_hits.size() != 0) @(posedge clk);
  endtask

  // one byte: optional gap, then hold valid until accepted
  task automatic send_byte(input logic [7:0] b, input logic lst);
    if (press_on && $urandom_range(0, 39) == 0) wait_drained();
    if (send_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_image();
    int i;
    for (i = 0; i < image_q.size(); i++) begin
      send_byte(image_q[i], i == image_q.size() - 1);
      sent++;
    end
  endtask

  // a register write takes effect at the edge where cfg_we is high
  task automatic cfg_write(input wbps_pkg::cfg_reg_t idx, input logic [63:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
  endtask

  // write the selected registers once the block has gone quiet;
  // an image that ended after its hit leaves no result, so pad past the latency
  task automatic configure(input bit [4:0] sel, input logic [63:0] lo,
                           input logic [63:0] hi, input logic [63:0] mask,
                           input logic [63:0] len, input logic [63:0] addr);
    wait_drained();
    repeat (4) @(posedge clk);
    if (sel[0]) cfg_write(wbps_pkg::CFG_PAT_LOW, lo);
    if (sel[1]) cfg_write(wbps_pkg::CFG_PAT_HIGH, hi);
    if (sel[2]) cfg_write(wbps_pkg::CFG_CARE_MASK, mask);
    if (sel[3]) cfg_write(wbps_pkg::CFG_PAT_LEN, len);
    if (sel[4]) cfg_write(wbps_pkg::CFG_BASE_ADDR, addr);
    cfg_we <= 1'b0;
  endtask

  // lengths: mostly short, with full depth, zero and out of range mixed in
  function automatic logic [63:0] pick_len();
    logic [63:0] v;
    int r;
    r = $urandom_range(0, 19);
    if (r < 12)      v = $urandom_range(1, 6);
    else if (r < 15) v = $urandom_range(7, wbps_pkg::PATTERN_MAX - 1);
    else if (r < 17) v = wbps_pkg::PATTERN_MAX;
    else if (r < 18) v = 0;
    else             v = $urandom_range(wbps_pkg::PATTERN_MAX + 1, 31);
    // junk above the field is dropped by the register
    if ($urandom_range(0, 5) == 0) v = v | (rand64() << wbps_pkg::LEN_W);
    return v;
  endfunction

  function automatic logic [63:0] pick_care();
    logic [63:0] v;
    case ($urandom_range(0, 5))
      0, 1, 2: v = 64'hFFFF;
      3:       v = $urandom_range(0, 16'hFFFF);
      4:       v = '0;
      default: v = rand64();
    endcase
    return v;
  endfunction

  function automatic logic [63:0] pick_base();
    logic [63:0] v;
    case ($urandom_range(0, 4))
      0:       v = '0;
      1:       v = '1;
      2:       v = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 40);
      default: v = rand64();
    endcase
    return v;
  endfunction

  // mostly a planted pattern with random filler around it, some with one
  // pattern byte spoiled, the rest plain noise
  function automatic void build_image();
    int kind;
    int len;
    int pre;
    int j;
    image_q.delete();
    kind = $urandom_range(0, 9);
    len  = sb.plen;
    if (kind >= 8 || len == 0 || len > wbps_pkg::PATTERN_MAX) begin
      repeat ($urandom_range(1, 20)) image_q = {image_q, 8'($urandom)};
    end else begin
      pre = $urandom_range(0, 6);
      repeat (pre) image_q = {image_q, 8'($urandom)};
      for (j = 0; j < len; j++)
        image_q = {image_q, (sb.care[j] ? sb.pattern_byte(j) : 8'($urandom))};
      if (kind == 7) begin
        j = $urandom_range(0, len - 1);
        image_q[pre+j] = image_q[pre+j] ^ 8'($urandom_range(1, 255));
      end
      repeat ($urandom_range(0, 5)) image_q = {image_q, 8'($urandom)};
    end
  endfunction

  initial begin
    int nimg;
    int guard;
    sb           = new();
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data_byte <= '0;
    in_last_byte <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= wbps_pkg::CFG_PAT_LOW;
    cfg_wdata    <= '0;
    send_idle    = 1'b0;
    recv_idle    = 1'b0;
    press_on     = 1'b0;
    sent         = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // zero length out of reset: the last byte reports no hit
    image_q = {8'h00, 8'hFF};
    send_image();

    // three byte pattern, top base address so the sum wraps
    configure(5'b11111, 64'h0000_0000_0090_5A4D, '1, 64'hFFFF, 64'd3, '1);
    // image shorter than the pattern
    image_q = {8'h4D, 8'h5A};
    send_image();
    // hit on the last byte
    image_q = {8'h4D, 8'h5A, 8'h90};
    send_image();
    // hit at offset 1 wraps to zero, bytes after it stay silent
    image_q = {8'h11, 8'h4D, 8'h5A, 8'h90, 8'h22, 8'h33};
    send_image();

    // length beyond the window depth never hits, base zero
    configure(5'b11000, '0, '0, '0, 64'd17, '0);
    image_q = {8'h4D, 8'h5A, 8'h90};
    send_image();

    // all wildcard single byte hits on the first byte
    configure(5'b01100, '0, '0, '0, 64'd1, '0);
    image_q = {8'hFF};
    send_image();

    // leading wildcard, second byte must be ff
    configure(5'b11101, 64'h0000_0000_0000_FF00, '0, 64'h0002, 64'd2, 64'h1000);
    image_q = {8'h00, 8'h00, 8'hFF};
    send_image();

    // random images, reconfigured now and then between images
    sent     = 0;
    nimg     = 0;
    press_on = 1'b1;
    while (sent < 600) begin
      if (sent >= 540) begin
        // quiet tail: no gaps, no stalls
        send_idle = 1'b0;
        recv_idle = 1'b0;
        press_on  = 1'b0;
      end else begin
        send_idle = $urandom_range(0, 3) != 0;
        recv_idle = $urandom_range(0, 3) != 0;
      end
      if (nimg == 0 || (sent < 540 && $urandom_range(0, 2) == 0))
        configure(5'($urandom_range(1, 31)), rand64(), rand64(), pick_care(),
                  pick_len(), pick_base());
      build_image();
      send_image();
      nimg++;
    end

    // drain, then allow for the pipeline before judging
    in_valid <= 1'b0;
    guard = 0;
    while (sb.pending_hits.size() != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (sb.pending_hits.size() != 0)
      sb.report($sformatf("%0d predicted results never arrived", sb.pending_hits.size()));
    if (sb.errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
